// ===== design/ppphi_pkg.sv =====
// Shared types and fixed-point constants for the pair-production phi(k) core.
// Used by the core top level and ppphi_log2; depends on nothing else.
package ppphi_pkg;

  localparam int K_W = 48;
  localparam int PHI_W = 64;
  localparam int IN_FRAC_BITS_DEF = 16;
  localparam int OUT_FRAC_BITS_DEF = 16;

  // Fraction bits delivered by the log2 squaring chain.
  localparam int LG_FRAC_W = 24;

  // Rational-fit constants, middle range.
  localparam logic [31:0] C1_Q32 = 32'd3456589680;
  localparam logic [29:0] C2_Q32 = 30'd626635728;
  localparam logic [22:0] C3_Q32 = 23'd4883378;
  localparam logic [14:0] C4_Q32 = 15'd16660;
  localparam logic [22:0] PI12_Q24 = 23'd4392265;
  localparam logic [63:0] ONE_Q52 = 64'h0010_0000_0000_0000;

  // Asymptotic-fit constants, upper range.
  localparam logic [31:0] LN2_Q32 = 32'd2977044472;
  localparam logic [50:0] D0_Q44 = 51'd1514159452842885;
  localparam logic [25:0] D1_Q20 = 26'd53435433;
  localparam logic [23:0] D2_Q20 = 24'd15151923;
  localparam logic [21:0] D3_Q20 = 22'd2796203;
  localparam logic [25:0] F1_Q24 = 26'd48821699;
  localparam logic [30:0] F2_Q24 = 31'd1314494874;
  localparam logic [34:0] F3_Q24 = 35'd30819745792;
  localparam logic [57:0] ONE_Q56 = 58'h100_0000_0000_0000;

  typedef enum logic [1:0] {
    RG_LOW,
    RG_MID,
    RG_UP
  } region_t;

  // Side data that rides along the log2 chain.
  typedef struct packed {
    logic [K_W-1:0] k;
    region_t        rg;
    logic [63:0]    mdvd;
    logic [31:0]    mden;
  } ftag_t;

  // Side data that rides along the reciprocal divider.
  typedef struct packed {
    ftag_t       f;
    logic [61:0] s44;
  } utag_t;

  // Side data that rides along the final divider.
  typedef struct packed {
    logic [K_W-1:0] k;
    region_t        rg;
  } dtag_t;

endpackage

// ===== design/pair_production_phi_approx_core.sv =====
// Top level of the pair-production phi(k) core: rational and asymptotic fits.
// Depends on ppphi_pkg, ppphi_log2 and ppphi_div.
//
//   Channel | Signals                          | Direction | Transfer when
//   --------+----------------------------------+-----------+-----------------------
//   input   | in_valid, in_ready, energy_ratio | into core | in_valid && in_ready
//   output  | out_valid, out_ready, phi_value, | from core | out_valid && out_ready
//           | saturated                        |           |
//
// One item enters per cycle while the pipeline advances. Most of the pipeline depth
// lies in the 24-stage log2 squaring chain, the reciprocal divider (one bit per stage)
// and the 64-stage final divider.
// Reset clears only the valid bits; the payload registers settle as items flow.
// The whole pipeline advances together; it holds only while the output
// register is full and out_ready is low, so nothing is lost or repeated.
module pair_production_phi_approx_core import ppphi_pkg::*; #(
  parameter int IN_FRAC_BITS  = IN_FRAC_BITS_DEF,
  parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [K_W-1:0]   energy_ratio,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [PHI_W-1:0] phi_value,
  output logic             saturated
);

  // Region thresholds and format shifts, all fixed at elaboration.
  localparam logic [K_W-1:0] K_TWO   = K_W'(2) << IN_FRAC_BITS;
  localparam logic [K_W-1:0] K_LIMIT = K_W'(25) << IN_FRAC_BITS;
  localparam int TSH_R = (IN_FRAC_BITS >= 20) ? IN_FRAC_BITS - 20 : 0;
  localparam int TSH_L = (IN_FRAC_BITS < 20) ? 20 - IN_FRAC_BITS : 0;
  localparam int UDV_W = (IN_FRAC_BITS + 33 > 48) ? IN_FRAC_BITS + 33 : 48;
  localparam logic [UDV_W-1:0] UDV_ONE = UDV_W'(1) << (32 + IN_FRAC_BITS);
  localparam int MSH = 24 - OUT_FRAC_BITS;
  localparam logic [63:0] MHALF = (64'(1) << MSH) >> 1;
  localparam int USH = IN_FRAC_BITS + 20 - OUT_FRAC_BITS;
  localparam logic [88:0] UHALF = (89'(1) << USH) >> 1;

  logic adv;

  // Input register.
  logic           s0_vld;
  logic [K_W-1:0] s0_k;

  // Middle-range front end: t, its powers, the fit products.
  logic           s1_vld, s2_vld, s3_vld, s4_vld, s5_vld, s6_vld;
  logic [K_W-1:0] s1_k, s2_k, s3_k, s4_k, s5_k;
  region_t        s1_rg, s2_rg, s3_rg, s4_rg, s5_rg;
  logic [24:0]    s1_t, s2_t, s3_t;
  logic [29:0]    s2_t2, s3_t2;
  logic [33:0]    s3_t3;
  logic [38:0]    s3_t4;
  logic [56:0]    s4_pc1;
  logic [61:0]    s4_pc2;
  logic [56:0]    s4_pc3;
  logic [53:0]    s4_pc4;
  logic [61:0]    s4_ppi;
  logic [63:0]    s5_den52;
  logic [61:0]    s5_num44;
  ftag_t          s6_tag;

  logic [K_W-1:0] traw_next;
  region_t        s1_rg_next;
  logic [49:0]    s2_sq_next;
  logic [54:0]    s3_cube_next;
  logic [59:0]    s3_quad_next;
  logic [63:0]    s5_pos_next;
  logic [31:0]    s6_den_next;

  // Log2 outputs and the ln-polynomial stages.
  logic                 lg_vld;
  logic [5:0]           lg_e;
  logic [LG_FRAC_W-1:0] lg_frac;
  ftag_t                lg_tag;
  logic [29:0]          lg_next;
  logic [61:0]          l1_prod_next;
  logic [57:0]          l2_prod_next;
  logic [62:0]          l3_prod_next;
  logic [61:0]          l5_pos_next, l5_neg_next;

  logic        l1_vld, l2_vld, l3_vld, l4_vld, l5_vld;
  ftag_t       l1_tag, l2_tag, l3_tag, l4_tag;
  logic [28:0] l1_l, l2_l, l3_l;
  logic [33:0] l2_l2, l3_l2;
  logic [38:0] l3_l3;
  logic [54:0] l4_pd1;
  logic [57:0] l4_pd2;
  logic [60:0] l4_pd3;
  utag_t       l5_tag;
  logic [UDV_W-1:0] l5_udvd;

  // Reciprocal divider outputs and the inverse-power stages.
  logic             ud_vld;
  logic [UDV_W-1:0] ud_quo;
  utag_t            ud_tag;
  logic [57:0]      u1_prod_next;
  logic [53:0]      u2_prod_next;
  logic [57:0]      u4_sf_next;
  logic [56:0]      u4_den56_next;
  logic [24:0]      u4_den24_next;

  logic        u1_vld, u2_vld, u3_vld, u4_vld, u5_vld;
  utag_t       u1_tag, u2_tag, u3_tag, u4_tag;
  logic [28:0] u1_u, u2_u;
  logic [24:0] u1_u2, u2_u2;
  logic [21:0] u2_u3;
  logic [54:0] u3_pf1;
  logic [55:0] u3_pf2;
  logic [56:0] u3_pf3;
  logic [24:0] u4_den24;
  logic [63:0] u5_dvd;
  logic [31:0] u5_dvs;
  dtag_t       u5_tag;

  // Final divider outputs and the back end.
  logic        dv_vld;
  logic [63:0] dv_quo;
  dtag_t       dv_tag;

  logic        f1_vld, f2_vld;
  region_t     f1_rg, f2_rg;
  logic [63:0] f1_mphi, f2_mphi;
  logic [43:0] f1_pll, f1_plh, f1_phl, f1_phh;
  logic [87:0] f2_prod;
  logic [88:0] f3_rnd_next;
  logic        f3_sat_next;

  // The whole pipeline moves whenever the output register can take a result.
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  always_comb begin
    traw_next = s0_k - K_TWO;
    if (s0_k < K_TWO) begin
      s1_rg_next = RG_LOW;
    end else if (s0_k < K_LIMIT) begin
      s1_rg_next = RG_MID;
    end else begin
      s1_rg_next = RG_UP;
    end
    s2_sq_next   = 50'(s1_t) * 50'(s1_t);
    s3_cube_next = 55'(s2_t2) * 55'(s2_t);
    s3_quad_next = 60'(s2_t2) * 60'(s2_t2);
    s5_pos_next  = ONE_Q52 + 64'(s4_pc1) + 64'(s4_pc2) + 64'(s4_pc3);
    s6_den_next  = 32'((s5_den52 + 64'h8000_0000) >> 32);
  end

  // Valid bits travel beside the data; everything else is payload.
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_vld    <= 1'b0;
      s1_vld    <= 1'b0;
      s2_vld    <= 1'b0;
      s3_vld    <= 1'b0;
      s4_vld    <= 1'b0;
      s5_vld    <= 1'b0;
      s6_vld    <= 1'b0;
      l1_vld    <= 1'b0;
      l2_vld    <= 1'b0;
      l3_vld    <= 1'b0;
      l4_vld    <= 1'b0;
      l5_vld    <= 1'b0;
      u1_vld    <= 1'b0;
      u2_vld    <= 1'b0;
      u3_vld    <= 1'b0;
      u4_vld    <= 1'b0;
      u5_vld    <= 1'b0;
      f1_vld    <= 1'b0;
      f2_vld    <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s0_vld    <= in_valid;
      s1_vld    <= s0_vld;
      s2_vld    <= s1_vld;
      s3_vld    <= s2_vld;
      s4_vld    <= s3_vld;
      s5_vld    <= s4_vld;
      s6_vld    <= s5_vld;
      l1_vld    <= lg_vld;
      l2_vld    <= l1_vld;
      l3_vld    <= l2_vld;
      l4_vld    <= l3_vld;
      l5_vld    <= l4_vld;
      u1_vld    <= ud_vld;
      u2_vld    <= u1_vld;
      u3_vld    <= u2_vld;
      u4_vld    <= u3_vld;
      u5_vld    <= u4_vld;
      f1_vld    <= dv_vld;
      f2_vld    <= f1_vld;
      out_valid <= f2_vld;
    end
  end

  // Middle range: t = k - 2 in Q20, its powers rounded to Q20, then the
  // denominator in Q52 and the numerator in Q44. A denominator that is not
  // positive is forced to one LSB.
  always_ff @(posedge clk) begin
    if (adv) begin
      s0_k   <= energy_ratio;

      s1_k   <= s0_k;
      s1_rg  <= s1_rg_next;
      s1_t   <= 25'((traw_next >> TSH_R) << TSH_L);

      s2_k   <= s1_k;
      s2_rg  <= s1_rg;
      s2_t   <= s1_t;
      s2_t2  <= 30'((s2_sq_next + 50'd524288) >> 20);

      s3_k   <= s2_k;
      s3_rg  <= s2_rg;
      s3_t   <= s2_t;
      s3_t2  <= s2_t2;
      s3_t3  <= 34'((s3_cube_next + 55'd524288) >> 20);
      s3_t4  <= 39'((s3_quad_next + 60'd524288) >> 20);

      s4_k   <= s3_k;
      s4_rg  <= s3_rg;
      s4_pc1 <= 57'(C1_Q32) * 57'(s3_t);
      s4_pc2 <= 62'(C2_Q32) * 62'(s3_t2);
      s4_pc3 <= 57'(C3_Q32) * 57'(s3_t3);
      s4_pc4 <= 54'(C4_Q32) * 54'(s3_t4);
      s4_ppi <= 62'(PI12_Q24) * 62'(s3_t4);

      s5_k     <= s4_k;
      s5_rg    <= s4_rg;
      s5_den52 <= (s5_pos_next > 64'(s4_pc4)) ? s5_pos_next - 64'(s4_pc4) : 64'd1;
      s5_num44 <= s4_ppi;

      s6_tag.k    <= s5_k;
      s6_tag.rg   <= s5_rg;
      s6_tag.mden <= (s6_den_next == '0) ? 32'd1 : s6_den_next;
      s6_tag.mdvd <= 64'(s5_num44) +
                     64'(((s6_den_next == '0) ? 32'd1 : s6_den_next) >> 1);
    end
  end

  ppphi_log2 #(
    .TAG_W ($bits(ftag_t))
  ) u_log2 (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_vld   (s6_vld),
    .in_k     (s6_tag.k),
    .in_tag   (s6_tag),
    .out_vld  (lg_vld),
    .out_e    (lg_e),
    .out_frac (lg_frac),
    .out_tag  (lg_tag)
  );

  // Upper range: ln k in Q24 from log2 k, its square and cube, and the cubic
  // in Q44 (clamped at zero). The reciprocal dividend is prepared alongside.
  always_comb begin
    lg_next      = {lg_e - 6'(IN_FRAC_BITS), lg_frac};
    l1_prod_next = 62'(lg_next) * 62'(LN2_Q32);
    l2_prod_next = 58'(l1_l) * 58'(l1_l);
    l3_prod_next = 63'(l2_l2) * 63'(l2_l);
    l5_pos_next  = 62'(l4_pd1) + 62'(l4_pd3);
    l5_neg_next  = 62'(l4_pd2) + 62'(D0_Q44);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      l1_tag <= lg_tag;
      l1_l   <= 29'((l1_prod_next + 62'h8000_0000) >> 32);

      l2_tag <= l1_tag;
      l2_l   <= l1_l;
      l2_l2  <= 34'((l2_prod_next + 58'h80_0000) >> 24);

      l3_tag <= l2_tag;
      l3_l   <= l2_l;
      l3_l2  <= l2_l2;
      l3_l3  <= 39'((l3_prod_next + 63'h80_0000) >> 24);

      l4_tag <= l3_tag;
      l4_pd1 <= 55'(D1_Q20) * 55'(l3_l);
      l4_pd2 <= 58'(D2_Q20) * 58'(l3_l2);
      l4_pd3 <= 61'(D3_Q20) * 61'(l3_l3);

      l5_tag.f   <= l4_tag;
      l5_tag.s44 <= (l5_pos_next > l5_neg_next) ? l5_pos_next - l5_neg_next : '0;
      l5_udvd    <= UDV_ONE + UDV_W'(l4_tag.k >> 1);
    end
  end

  // Reciprocal 1/k in Q32, rounded.
  ppphi_div #(
    .NUM_W (UDV_W),
    .DEN_W (K_W),
    .TAG_W ($bits(utag_t))
  ) u_recip (
    .clk     (clk),
    .rst     (rst),
    .en      (adv),
    .in_vld  (l5_vld),
    .in_num  (l5_udvd),
    .in_den  (l5_tag.f.k),
    .in_tag  (l5_tag),
    .out_vld (ud_vld),
    .out_quo (ud_quo),
    .out_tag (ud_tag)
  );

  // Inverse powers, the f-sum in Q56 and the denominator truncated to Q24.
  // In the upper range 1/k stays below 2^28 in Q32.
  always_comb begin
    u1_prod_next  = 58'(ud_quo[28:0]) * 58'(ud_quo[28:0]);
    u2_prod_next  = 54'(u1_u2) * 54'(u1_u);
    u4_sf_next    = 58'(u3_pf1) + 58'(u3_pf2) + 58'(u3_pf3);
    u4_den56_next = (u4_sf_next < ONE_Q56) ? 57'(ONE_Q56 - u4_sf_next) : 57'd1;
    u4_den24_next = 25'(u4_den56_next >> 32);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      u1_tag <= ud_tag;
      u1_u   <= ud_quo[28:0];
      u1_u2  <= 25'((u1_prod_next + 58'h8000_0000) >> 32);

      u2_tag <= u1_tag;
      u2_u   <= u1_u;
      u2_u2  <= u1_u2;
      u2_u3  <= 22'((u2_prod_next + 54'h8000_0000) >> 32);

      u3_tag <= u2_tag;
      u3_pf1 <= 55'(F1_Q24) * 55'(u2_u);
      u3_pf2 <= 56'(F2_Q24) * 56'(u2_u2);
      u3_pf3 <= 57'(F3_Q24) * 57'(u2_u3);

      u4_tag   <= u3_tag;
      u4_den24 <= (u4_den24_next == '0) ? 25'd1 : u4_den24_next;

      // Both ranges share the final divider; each brings its own operands.
      u5_tag.k  <= u4_tag.f.k;
      u5_tag.rg <= u4_tag.f.rg;
      if (u4_tag.f.rg == RG_MID) begin
        u5_dvd <= u4_tag.f.mdvd;
        u5_dvs <= u4_tag.f.mden;
      end else begin
        u5_dvd <= 64'(u4_tag.s44) + 64'(u4_den24 >> 1);
        u5_dvs <= 32'(u4_den24);
      end
    end
  end

  ppphi_div #(
    .NUM_W (64),
    .DEN_W (32),
    .TAG_W ($bits(dtag_t))
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .en      (adv),
    .in_vld  (u5_vld),
    .in_num  (u5_dvd),
    .in_den  (u5_dvs),
    .in_tag  (u5_tag),
    .out_vld (dv_vld),
    .out_quo (dv_quo),
    .out_tag (dv_tag)
  );

  // Back end. The middle quotient is Q24 and only needs rounding. The upper
  // ratio (Q20, below 2^40) is multiplied by k as four partial products, summed,
  // rounded to the output format and checked against the 64-bit range.
  always_comb begin
    f3_rnd_next = (89'(f2_prod) + UHALF) >> USH;
    f3_sat_next = |f3_rnd_next[88:64];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f1_rg   <= dv_tag.rg;
      f1_mphi <= (dv_quo + MHALF) >> MSH;
      f1_pll  <= 44'(dv_tag.k[23:0]) * 44'(dv_quo[19:0]);
      f1_plh  <= 44'(dv_tag.k[23:0]) * 44'(dv_quo[39:20]);
      f1_phl  <= 44'(dv_tag.k[47:24]) * 44'(dv_quo[19:0]);
      f1_phh  <= 44'(dv_tag.k[47:24]) * 44'(dv_quo[39:20]);

      f2_rg   <= f1_rg;
      f2_mphi <= f1_mphi;
      f2_prod <= 88'(f1_pll) + (88'(f1_plh) << 20) + (88'(f1_phl) << 24) +
                 (88'(f1_phh) << 44);

      case (f2_rg)
        RG_LOW: begin
          phi_value <= '0;
          saturated <= 1'b0;
        end
        RG_MID: begin
          phi_value <= f2_mphi;
          saturated <= 1'b0;
        end
        default: begin
          phi_value <= f3_sat_next ? '1 : f3_rnd_next[63:0];
          saturated <= f3_sat_next;
        end
      endcase
    end
  end

endmodule

// ===== design/ppphi_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with a side tag.
// Stand-alone; instantiated by the phi(k) core top level.
module ppphi_div #(
  parameter int NUM_W = 64,
  parameter int DEN_W = 32,
  parameter int TAG_W = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_vld,
  input  logic [NUM_W-1:0] in_num,
  input  logic [DEN_W-1:0] in_den,
  input  logic [TAG_W-1:0] in_tag,
  output logic             out_vld,
  output logic [NUM_W-1:0] out_quo,
  output logic [TAG_W-1:0] out_tag
);

  logic             vld_q [NUM_W];
  logic [DEN_W-1:0] rem_q [NUM_W];
  logic [NUM_W-1:0] wrd_q [NUM_W];
  logic [DEN_W-1:0] den_q [NUM_W];
  logic [TAG_W-1:0] tag_q [NUM_W];

  // The working word holds the unused dividend bits on top and collects
  // quotient bits from the bottom.
  for (genvar j = 0; j < NUM_W; j++) begin : g_stg
    logic             vld_in;
    logic [DEN_W-1:0] rem_in;
    logic [NUM_W-1:0] wrd_in;
    logic [DEN_W-1:0] den_in;
    logic [TAG_W-1:0] tag_in;
    logic [DEN_W:0]   trial;
    logic             take;

    if (j == 0) begin : g_head
      assign vld_in = in_vld;
      assign rem_in = '0;
      assign wrd_in = in_num;
      assign den_in = in_den;
      assign tag_in = in_tag;
    end else begin : g_body
      assign vld_in = vld_q[j-1];
      assign rem_in = rem_q[j-1];
      assign wrd_in = wrd_q[j-1];
      assign den_in = den_q[j-1];
      assign tag_in = tag_q[j-1];
    end

    assign trial = {rem_in, wrd_in[NUM_W-1]};
    assign take  = (trial >= {1'b0, den_in});

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[j] <= 1'b0;
      end else if (en) begin
        vld_q[j] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[j] <= take ? DEN_W'(trial - {1'b0, den_in}) : trial[DEN_W-1:0];
        wrd_q[j] <= {wrd_in[NUM_W-2:0], take};
        den_q[j] <= den_in;
        tag_q[j] <= tag_in;
      end
    end
  end

  assign out_vld = vld_q[NUM_W-1];
  assign out_quo = wrd_q[NUM_W-1];
  assign out_tag = tag_q[NUM_W-1];

endmodule

// ===== design/ppphi_log2.sv =====
// Pipelined log2: leading-one detect, normalize, then one squaring per stage.
// Depends on ppphi_pkg for the operand width and fraction length.
module ppphi_log2 import ppphi_pkg::*; #(
  parameter int TAG_W = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_vld,
  input  logic [K_W-1:0]       in_k,
  input  logic [TAG_W-1:0]     in_tag,
  output logic                 out_vld,
  output logic [5:0]           out_e,
  output logic [LG_FRAC_W-1:0] out_frac,
  output logic [TAG_W-1:0]     out_tag
);

  logic             a_vld;
  logic [5:0]       a_e;
  logic [K_W-1:0]   a_k;
  logic [TAG_W-1:0] a_tag;
  logic [5:0]       a_e_next;

  logic             b_vld;
  logic [5:0]       b_e;
  logic [30:0]      b_m;
  logic [TAG_W-1:0] b_tag;

  logic                 vld_q  [LG_FRAC_W];
  logic [30:0]          m_q    [LG_FRAC_W];
  logic [LG_FRAC_W-1:0] frac_q [LG_FRAC_W];
  logic [5:0]           e_q    [LG_FRAC_W];
  logic [TAG_W-1:0]     tag_q  [LG_FRAC_W];

  // Highest set bit wins.
  always_comb begin
    a_e_next = '0;
    for (int i = 0; i < K_W; i++) begin
      if (in_k[i]) begin
        a_e_next = 6'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
      b_vld <= 1'b0;
    end else if (en) begin
      a_vld <= in_vld;
      b_vld <= a_vld;
    end
  end

  // Shifting k up by 30 and down by e places the leading one at bit 30.
  always_ff @(posedge clk) begin
    if (en) begin
      a_e   <= a_e_next;
      a_k   <= in_k;
      a_tag <= in_tag;
      b_e   <= a_e;
      b_m   <= 31'({a_k, 30'd0} >> a_e);
      b_tag <= a_tag;
    end
  end

  for (genvar j = 0; j < LG_FRAC_W; j++) begin : g_sq
    logic                 vld_in;
    logic [30:0]          m_in;
    logic [LG_FRAC_W-1:0] frac_in;
    logic [5:0]           e_in;
    logic [TAG_W-1:0]     tag_in;
    logic [61:0]          sq;
    logic [31:0]          sq_hi;

    if (j == 0) begin : g_head
      assign vld_in  = b_vld;
      assign m_in    = b_m;
      assign frac_in = '0;
      assign e_in    = b_e;
      assign tag_in  = b_tag;
    end else begin : g_body
      assign vld_in  = vld_q[j-1];
      assign m_in    = m_q[j-1];
      assign frac_in = frac_q[j-1];
      assign e_in    = e_q[j-1];
      assign tag_in  = tag_q[j-1];
    end

    assign sq    = 62'(m_in) * 62'(m_in);
    assign sq_hi = sq[61:30];

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[j] <= 1'b0;
      end else if (en) begin
        vld_q[j] <= vld_in;
      end
    end

    // A square of two or more yields a one bit and is halved.
    always_ff @(posedge clk) begin
      if (en) begin
        m_q[j]    <= sq_hi[31] ? sq_hi[31:1] : sq_hi[30:0];
        frac_q[j] <= {frac_in[LG_FRAC_W-2:0], sq_hi[31]};
        e_q[j]    <= e_in;
        tag_q[j]  <= tag_in;
      end
    end
  end

  assign out_vld  = vld_q[LG_FRAC_W-1];
  assign out_e    = e_q[LG_FRAC_W-1];
  assign out_frac = frac_q[LG_FRAC_W-1];
  assign out_tag  = tag_q[LG_FRAC_W-1];

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for pair_production_phi_approx_core.
// Depends on ppphi_pkg and the core RTL; an internal fixed-point predictor
// computes phi(k) for every transfer and checks it against the output channel.
`timescale 1ns / 100ps

module tb;
  import ppphi_pkg::*;

  localparam int LATENCY = 160;

  logic             clk;
  logic             rst;
  logic             in_valid;
  logic             in_ready;
  logic [K_W-1:0]   energy_ratio;
  logic             out_valid;
  logic             out_ready;
  logic [PHI_W-1:0] phi_value;
  logic             saturated;

  // Expected outputs, oldest first.
  logic [PHI_W-1:0] phi_expected[$];
  logic             sat_expected[$];

  int unsigned mismatches;
  int unsigned results_seen;
  int unsigned items_sent;
  int unsigned saturated_seen;

  // Idle and stall rates in percent, changed from phase to phase.
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  // Cycles left in a forced hold-off of the output channel.
  int unsigned hold_off_cycles;

  pair_production_phi_approx_core dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .energy_ratio(energy_ratio),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .phi_value(phi_value),
    .saturated(saturated)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Rounding right shift: add half an LSB, then truncate.
  function automatic logic [63:0] shr_round(logic [63:0] x, int s);
    if (s <= 0) begin
      return x;
    end
    return (x + (64'd1 << (s - 1))) >> s;
  endfunction

  // Middle range: rational fit in t = k - 2.
  function automatic logic [63:0] phi_rational(logic [63:0] k);
    logic [63:0] tr, t, t2, t3, t4, pos, neg, den52, den20, num44, q24;
    tr = k - (64'd2 << IN_FRAC_BITS_DEF);
    if (IN_FRAC_BITS_DEF >= 20) begin
      t = tr >> (IN_FRAC_BITS_DEF - 20);
    end else begin
      t = tr << (20 - IN_FRAC_BITS_DEF);
    end
    t2 = shr_round(t * t, 20);
    t3 = shr_round(t2 * t, 20);
    t4 = shr_round(t2 * t2, 20);
    pos = ONE_Q52 + 64'(C1_Q32) * t + 64'(C2_Q32) * t2 + 64'(C3_Q32) * t3;
    neg = 64'(C4_Q32) * t4;
    den52 = (pos > neg) ? pos - neg : 64'd1;
    den20 = shr_round(den52, 32);
    if (den20 == '0) begin
      den20 = 64'd1;
    end
    num44 = 64'(PI12_Q24) * t4;
    q24 = (num44 + den20 / 2) / den20;
    return shr_round(q24, 24 - OUT_FRAC_BITS_DEF);
  endfunction

  // log2 k in Q24: leading one for the integer part, squaring for the fraction.
  function automatic logic [63:0] log2_fixed(logic [63:0] k);
    int e;
    logic [63:0] m, frac;
    e = 47;
    frac = '0;
    while (e > 0 && k[e] == 1'b0) begin
      e--;
    end
    if (e >= 30) begin
      m = k >> (e - 30);
    end else begin
      m = k << (30 - e);
    end
    for (int i = 0; i < 24; i++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd2 << 30)) begin
        m = m >> 1;
        frac[0] = 1'b1;
      end
    end
    return (64'(e - IN_FRAC_BITS_DEF) << 24) | frac;
  endfunction

  // Upper range: k times a cubic in ln k over one minus inverse powers of k.
  function automatic void phi_asymptotic(input logic [63:0] k, output logic [63:0] phi,
                                         output logic sat);
    logic [63:0] lg, ln_k, ln2_k, ln3_k, pos, neg, s44, u, u2, u3, sf, den56, den24, r20;
    logic [127:0] prod;
    int s;
    lg = log2_fixed(k);
    ln_k = shr_round(lg * 64'(LN2_Q32), 32);
    ln2_k = shr_round(ln_k * ln_k, 24);
    ln3_k = shr_round(ln2_k * ln_k, 24);
    pos = 64'(D1_Q20) * ln_k + 64'(D3_Q20) * ln3_k;
    neg = 64'(D2_Q20) * ln2_k + 64'(D0_Q44);
    s44 = (pos > neg) ? pos - neg : 64'd0;
    u = ((64'd1 << (32 + IN_FRAC_BITS_DEF)) + k / 2) / k;
    u2 = shr_round(u * u, 32);
    u3 = shr_round(u2 * u, 32);
    sf = 64'(F1_Q24) * u + 64'(F2_Q24) * u2 + 64'(F3_Q24) * u3;
    den56 = (sf < 64'(ONE_Q56)) ? 64'(ONE_Q56) - sf : 64'd1;
    den24 = den56 >> 32;
    if (den24 == '0) begin
      den24 = 64'd1;
    end
    r20 = (s44 + den24 / 2) / den24;
    s = IN_FRAC_BITS_DEF + 20 - OUT_FRAC_BITS_DEF;
    prod = (128'(k) * 128'(r20) + (128'd1 << (s - 1))) >> s;
    if (prod[127:64] != '0) begin
      phi = '1;
      sat = 1'b1;
    end else begin
      phi = prod[63:0];
      sat = 1'b0;
    end
  endfunction

  // Full phi(k) for one energy ratio; appends the expected output.
  task automatic predict_phi(input logic [K_W-1:0] ratio);
    logic [63:0] k, phi;
    logic sat;
    k = 64'(ratio);
    sat = 1'b0;
    if (k < (64'd2 << IN_FRAC_BITS_DEF)) begin
      phi = '0;
    end else if (k < (64'd25 << IN_FRAC_BITS_DEF)) begin
      phi = phi_rational(k);
    end else begin
      phi_asymptotic(k, phi, sat);
    end
    phi_expected = {phi_expected, phi};
    sat_expected = {sat_expected, sat};
  endtask

  // Sends one energy ratio, with random idle cycles first, and records its
  // expected result once the transfer happens.
  task automatic send_ratio(input logic [K_W-1:0] ratio);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    energy_ratio <= ratio;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    predict_phi(ratio);
    items_sent++;
  endtask

  // Drops the input valid and waits until every expected result has arrived,
  // then lets the pipeline run empty.
  task automatic drain_outputs();
    in_valid <= 1'b0;
    @(posedge clk);
    while (phi_expected.size() != 0) begin
      @(posedge clk);
    end
    repeat (LATENCY) @(posedge clk);
  endtask

  // Random k, weighted toward the region boundaries and each fit's range.
  function automatic logic [K_W-1:0] random_ratio();
    int unsigned pick;
    int unsigned w;
    pick = $urandom_range(99);
    if (pick < 10) begin
      return K_W'($urandom_range(2 << 16));
    end else if (pick < 35) begin
      return K_W'($urandom_range(25 << 16, 2 << 16));
    end else if (pick < 45) begin
      // Near the two region boundaries.
      if ($urandom_range(1)) begin
        return K_W'((2 << 16) + $urandom_range(8) - 4);
      end
      return K_W'((25 << 16) + $urandom_range(8) - 4);
    end else if (pick < 75) begin
      // Upper range with a random magnitude.
      w = $urandom_range(47, 21);
      return K_W'(({$urandom(), $urandom()} >> (63 - w)) | (64'd25 << 16));
    end
    return K_W'({$urandom(), $urandom()});
  endfunction

  task automatic test_boundaries();
    logic [K_W-1:0] ratios[$];
    send_idle_pct = 0;
    recv_stall_pct = 0;
    ratios = {
      48'd0, 48'd1, 48'h1_FFFF, 48'h2_0000, 48'h2_0001, 48'h3_0000, 48'h8_8000,
      48'h18_FFFF, 48'h19_0000, 48'h19_0001, 48'h1A_0000, 48'h64_0000,
      48'h1_0000_0000, 48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000, 48'hAAAA_AAAA_AAAA,
      48'h5555_5555_5555, 48'hFFFF_0000_0000, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFE
    };
    foreach (ratios[i]) begin
      send_ratio(ratios[i]);
    end
    drain_outputs();
  endtask

  task automatic test_random_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                                   input int unsigned count);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) begin
      send_ratio(random_ratio());
    end
    drain_outputs();
  endtask

  // The output channel stalls for a long stretch while items keep coming, so
  // the pipeline fills and the input channel has to back off.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off_cycles = 3 * LATENCY;
    repeat (250) begin
      send_ratio(random_ratio());
    end
    drain_outputs();
  endtask

  // Receiver: random stalls plus the counted hold-off.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_off_cycles != 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Checker: compares each output transfer with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (phi_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected output: phi_value=%h saturated=%b", phi_value, saturated);
        end
      end else begin
        if (phi_value !== phi_expected[0] || saturated !== sat_expected[0]) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected phi_value=%h saturated=%b, got %h %b",
                     phi_expected[0], sat_expected[0], phi_value, saturated);
          end
        end
        if (saturated === 1'b1) begin
          saturated_seen++;
        end
        void'(phi_expected.pop_front());
        void'(sat_expected.pop_front());
      end
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    energy_ratio = '0;
    mismatches = 0;
    results_seen = 0;
    items_sent = 0;
    saturated_seen = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off_cycles = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_boundaries();
    test_random_phase(0, 0, 150);
    test_random_phase(72, 0, 140);
    test_random_phase(0, 72, 140);
    test_random_phase(13, 13, 150);
    test_backpressure();

    if (phi_expected.size() != 0) begin
      mismatches++;
    end
    $display("Sent %0d energy ratios across all regions and handshake phases;", items_sent);
    $display("checked %0d results, %0d of them saturated.", results_seen, saturated_seen);
    if (mismatches == 0) begin
      $display("pair_production_phi_approx_core regression: pass");
    end else begin
      $display("pair_production_phi_approx_core regression: fail");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #4000000;
    $display("pair_production_phi_approx_core regression: fail");
    $finish;
  end

endmodule

// ===== sim.f =====
design/ppphi_pkg.sv
design/ppphi_div.sv
design/ppphi_log2.sv
design/pair_production_phi_approx_core.sv
tb/sv/tb.sv
